// ===== rtl/hca_pkg.sv =====
// Shared types, widths and helper functions for the hypercomplex ALU.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps
`default_nettype none

package hca_pkg;

    // Fixed-point format: signed, FRAC_BITS fraction bits (8 to 30).
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LIN_W     = DATA_W + 1;           // add, subtract, conjugate
    localparam int PROD_W    = 2 * DATA_W;           // one 32 x 32 product
    localparam int TERM_W    = PROD_W + DATA_W;      // product times u*u
    localparam int SUM_W     = TERM_W + 1;           // real part and norm sums
    localparam int CROSS_W   = PROD_W + 1;           // u-part cross sums
    localparam int NUM_W     = SUM_W + FRAC_BITS;    // dividend magnitude
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int MAG_W     = DATA_W + 2;           // rounded magnitude

    // Input queue between the front and back ends (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Reset value of u*u: -1.0, ordinary complex numbers.
    localparam logic signed [DATA_W-1:0] UNIT_SQ_RESET =
        DATA_W'(-(longint'(1) << FRAC_BITS));

    // Operation codes on the mode input.
    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_CONJ = 3'd3,
        MODE_DIV  = 3'd4
    } mode_t;

    // Operation class carried through the queue.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_CONJ,
        OP_DIV
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DIV = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    // Divider sequencer states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // One queued word.
    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  x_real;
        logic signed [DATA_W-1:0]  x_unit;
        logic signed [DATA_W-1:0]  y_real;
        logic signed [DATA_W-1:0]  y_unit;
    } item_t;

    // A saturated result part.
    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_res_t;

    // Clamp a sign and rounded magnitude to the 32-bit signed range.
    // ovf flags magnitude bits above the ones passed in.
    function automatic sat_res_t sat_mag(input logic neg, input logic ovf,
                                         input logic [MAG_W-1:0] mag);
        sat_res_t r;
        logic     over;
        over = ovf || mag[MAG_W-1] || mag[DATA_W] ||
               (neg ? (mag[DATA_W-1] && (|mag[DATA_W-2:0])) : mag[DATA_W-1]);
        if (over) begin
            r.val = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r.val = neg ? (~mag[DATA_W-1:0]) + DATA_W'(1) : mag[DATA_W-1:0];
        end
        r.sat = over;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hypercomplex_alu_core.sv =====
// Top level of the hypercomplex ALU: u*u register, front end and back end.
// Depends on hca_pkg, hca_front, hca_back (and hca_div below it).
`timescale 1ns / 1ps
`default_nettype none

// Arithmetic on numbers a + b*u in signed Q16.16, where u*u is programmable.
// Configuration: cfg_wr_data is written into u*u when cfg_wr_en is high;
// write it only while no word is in flight. Reset loads -1.0 (complex).
// Input: a word is taken at a clock edge where start is high and busy is
// low. busy rises when the four-word input queue is full.
// Output: each result is on res_real, res_unit and status for exactly one
// cycle while done is high; the receiver cannot hold it off.
// Add, subtract, conjugate and multiply stream through at one word per
// cycle while no divide holds the pipeline.
// Divide runs a one-bit-per-cycle divider (113 steps at 16 fraction bits)
// and holds the execution pipeline until it is done; later words wait
// in the queue and behind the divide, and all results leave in order.
// A zero norm returns zero with status 1 right away; saturation sets 2.
// Reset empties the queue and pipeline; no result is pending afterward.

module hypercomplex_alu_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic signed [hca_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                              start,
    input  logic [2:0]                        mode,
    input  logic signed [hca_pkg::DATA_W-1:0] x_real,
    input  logic signed [hca_pkg::DATA_W-1:0] x_unit,
    input  logic signed [hca_pkg::DATA_W-1:0] y_real,
    input  logic signed [hca_pkg::DATA_W-1:0] y_unit,
    output logic                              busy,
    output logic                              done,
    output logic signed [hca_pkg::DATA_W-1:0] res_real,
    output logic signed [hca_pkg::DATA_W-1:0] res_unit,
    output logic [1:0]                        status
);
    import hca_pkg::*;

    logic signed [DATA_W-1:0] unit_square_reg;
    logic                     q_valid;
    logic                     q_pop;
    item_t                    q_item;

    // Configuration register for u*u.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            unit_square_reg <= UNIT_SQ_RESET;
        end else if (cfg_wr_en) begin
            unit_square_reg <= cfg_wr_data;
        end
    end

    hca_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .mode    (mode),
        .x_real  (x_real),
        .x_unit  (x_unit),
        .y_real  (y_real),
        .y_unit  (y_unit),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    hca_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_square (unit_square_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .done        (done),
        .res_real    (res_real),
        .res_unit    (res_unit),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== rtl/hca_div.sv =====
// Bit-serial restoring divider with round-to-nearest and saturation.
// Depends on hca_pkg; used twice by hca_back.
`timescale 1ns / 1ps
`default_nettype none

module hca_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [hca_pkg::NUM_W-1:0]  num_mag,
    input  logic [hca_pkg::SUM_W-1:0]  den_mag,
    input  logic                       neg,
    output logic                       done,
    output hca_pkg::sat_res_t          result
);
    import hca_pkg::*;

    div_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [SUM_W-1:0]    den_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [DATA_W:0]     quo_reg;
    logic                ovf_reg;
    logic                neg_reg;
    logic                step;

    logic [SUM_W:0]      rem_shift;
    logic [SUM_W:0]      rem_diff;
    logic                rem_ge;
    logic                round_up;
    logic [MAG_W-1:0]    mag;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (go) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == '0) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        step = 1'b0;
        done = 1'b0;
        case (state_reg)
            DIV_RUN:  step = 1'b1;
            DIV_DONE: done = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // One quotient bit per cycle: shift in a dividend bit, compare, subtract.
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        rem_ge    = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (go && state_reg == DIV_IDLE) begin
            cnt_reg <= CNT_W'(NUM_W - 1);
            num_reg <= num_mag;
            den_reg <= den_mag;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= neg;
        end else if (step) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            num_reg <= num_reg << 1;
            rem_reg <= rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            quo_reg <= {quo_reg[DATA_W-1:0], rem_ge};
            ovf_reg <= ovf_reg | quo_reg[DATA_W];
        end
    end

    // Round half away from zero on the magnitude, then clamp.
    always_comb
    begin
        round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
        mag      = {1'b0, quo_reg} + MAG_W'(round_up);
        result   = sat_mag(neg_reg, ovf_reg, mag);
    end

`ifndef ASSERT_OFF
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == DIV_IDLE)
        else $error("divider started while running");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_RUN && cnt_reg == '0) |=> done)
        else $error("divider did not finish after last step");
`endif

endmodule

`default_nettype wire

// ===== rtl/hca_front.sv =====
// Front end: takes command words, decodes the mode and queues them.
// Depends on hca_pkg; feeds hca_back.
`timescale 1ns / 1ps
`default_nettype none

module hca_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [2:0]                        mode,
    input  logic signed [hca_pkg::DATA_W-1:0] x_real,
    input  logic signed [hca_pkg::DATA_W-1:0] x_unit,
    input  logic signed [hca_pkg::DATA_W-1:0] y_real,
    input  logic signed [hca_pkg::DATA_W-1:0] y_unit,
    output logic                              busy,
    output logic                              q_valid,
    output hca_pkg::item_t                    q_item,
    input  logic                              q_pop
);
    import hca_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    op_t               dec_op;

    // Mode decode; unused codes become a no-op.
    always_comb
    begin
        case (mode_t'(mode))
            MODE_ADD:  dec_op = OP_ADD;
            MODE_SUB:  dec_op = OP_SUB;
            MODE_MUL:  dec_op = OP_MUL;
            MODE_CONJ: dec_op = OP_CONJ;
            MODE_DIV:  dec_op = OP_DIV;
            default:   dec_op = OP_NONE;
        endcase
    end

    assign busy    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign push    = start && !busy;
    assign q_valid = count_reg != '0;
    assign q_item  = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{op: dec_op, x_real: x_real, x_unit: x_unit,
                                     y_real: y_real, y_unit: y_unit};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (q_pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/hca_back.sv =====
// Back end: multiply pipeline, rounding, saturation and serial division.
// Depends on hca_pkg and hca_div; pulls words from hca_front.
`timescale 1ns / 1ps
`default_nettype none

module hca_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [hca_pkg::DATA_W-1:0] unit_square,
    input  logic                              q_valid,
    input  hca_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              done,
    output logic signed [hca_pkg::DATA_W-1:0] res_real,
    output logic signed [hca_pkg::DATA_W-1:0] res_unit,
    output logic [1:0]                        status
);
    import hca_pkg::*;

    // Stage 1: raw products and linear results.
    logic                       s1_v_reg;
    op_t                        s1_op_reg;
    logic signed [LIN_W-1:0]    s1_lin_re_reg, s1_lin_un_reg;
    logic signed [PROD_W-1:0]   s1_rr_reg, s1_uu_reg, s1_ru_reg, s1_ur_reg;
    logic signed [PROD_W-1:0]   s1_yy_reg, s1_vv_reg;
    // Stage 2: partial products against u*u.
    logic                       s2_v_reg;
    op_t                        s2_op_reg;
    logic signed [LIN_W-1:0]    s2_lin_re_reg, s2_lin_un_reg;
    logic signed [PROD_W-1:0]   s2_rr_reg, s2_ru_reg, s2_ur_reg, s2_yy_reg;
    logic signed [PROD_W-1:0]   s2_uu_hi_reg, s2_vv_hi_reg;
    logic signed [PROD_W:0]     s2_uu_lo_reg, s2_vv_lo_reg;
    // Stage 3: full terms times u*u.
    logic                       s3_v_reg;
    op_t                        s3_op_reg;
    logic signed [LIN_W-1:0]    s3_lin_re_reg, s3_lin_un_reg;
    logic signed [PROD_W-1:0]   s3_rr_reg, s3_ru_reg, s3_ur_reg, s3_yy_reg;
    logic signed [TERM_W-1:0]   s3_tuu_reg, s3_tvv_reg;
    // Stage 4: exact sums.
    logic                       s4_v_reg;
    op_t                        s4_op_reg;
    logic signed [SUM_W-1:0]    s4_re_reg, s4_den_reg;
    logic signed [CROSS_W-1:0]  s4_un_reg;
    // Stage 5: sign and magnitude.
    logic                       s5_v_reg;
    op_t                        s5_op_reg;
    logic                       s5_re_neg_reg, s5_un_neg_reg, s5_den_neg_reg;
    logic [SUM_W-1:0]           s5_re_mag_reg, s5_den_mag_reg;
    logic [CROSS_W-1:0]         s5_un_mag_reg;
    logic                       s5_den_zero_reg;
    // Output word.
    logic                       out_v_reg;
    logic [DATA_W-1:0]          out_re_reg, out_un_reg;
    status_t                    out_st_reg;

    logic                       adv;
    logic                       div_item;
    logic                       div_go;
    logic                       div_busy_reg;
    logic                       done_re, done_un;
    sat_res_t                   div_re_res, div_un_res;

    logic signed [LIN_W-1:0]    lin_re, lin_un;
    logic signed [SUM_W-1:0]    sum_re, sum_den;
    logic signed [CROSS_W-1:0]  sum_un;
    logic [SUM_W-1:0]           re_sh;
    logic [CROSS_W-1:0]         un_sh;
    logic                       re_half, un_half;
    logic [MAG_W-1:0]           re_mag34, un_mag34;
    sat_res_t                   re_res, un_res;
    logic [DATA_W-1:0]          iss_re, iss_un;
    status_t                    iss_st;

    // Pipeline moves as a whole; only a division in the last stage holds it.
    assign div_item = s5_v_reg && s5_op_reg == OP_DIV && !s5_den_zero_reg;
    assign adv      = !div_item || done_re;
    assign div_go   = div_item && !div_busy_reg;
    assign q_pop    = adv && q_valid;

    // Stage 1 linear operations.
    always_comb
    begin
        case (q_item.op)
            OP_ADD: begin
                lin_re = LIN_W'(q_item.x_real) + LIN_W'(q_item.y_real);
                lin_un = LIN_W'(q_item.x_unit) + LIN_W'(q_item.y_unit);
            end
            OP_SUB: begin
                lin_re = LIN_W'(q_item.x_real) - LIN_W'(q_item.y_real);
                lin_un = LIN_W'(q_item.x_unit) - LIN_W'(q_item.y_unit);
            end
            OP_CONJ: begin
                lin_re = LIN_W'(q_item.x_real);
                lin_un = -LIN_W'(q_item.x_unit);
            end
            default: begin
                lin_re = '0;
                lin_un = '0;
            end
        endcase
    end

    // Stage 4 sums.
    always_comb
    begin
        sum_den = (SUM_W'(s3_yy_reg) <<< FRAC_BITS) - SUM_W'(s3_tvv_reg);
        case (s3_op_reg)
            OP_MUL: begin
                sum_re = (SUM_W'(s3_rr_reg) <<< FRAC_BITS) + SUM_W'(s3_tuu_reg);
                sum_un = CROSS_W'(s3_ru_reg) + CROSS_W'(s3_ur_reg);
            end
            OP_DIV: begin
                sum_re = (SUM_W'(s3_rr_reg) <<< FRAC_BITS) - SUM_W'(s3_tuu_reg);
                sum_un = CROSS_W'(s3_ur_reg) - CROSS_W'(s3_ru_reg);
            end
            OP_ADD, OP_SUB, OP_CONJ: begin
                sum_re = SUM_W'(s3_lin_re_reg);
                sum_un = CROSS_W'(s3_lin_un_reg);
            end
            default: begin
                sum_re = '0;
                sum_un = '0;
            end
        endcase
    end

    // Pipeline registers.
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_op_reg     <= q_item.op;
            s1_lin_re_reg <= lin_re;
            s1_lin_un_reg <= lin_un;
            s1_rr_reg     <= q_item.x_real * q_item.y_real;
            s1_uu_reg     <= q_item.x_unit * q_item.y_unit;
            s1_ru_reg     <= q_item.x_real * q_item.y_unit;
            s1_ur_reg     <= q_item.x_unit * q_item.y_real;
            s1_yy_reg     <= q_item.y_real * q_item.y_real;
            s1_vv_reg     <= q_item.y_unit * q_item.y_unit;

            s2_op_reg     <= s1_op_reg;
            s2_lin_re_reg <= s1_lin_re_reg;
            s2_lin_un_reg <= s1_lin_un_reg;
            s2_rr_reg     <= s1_rr_reg;
            s2_ru_reg     <= s1_ru_reg;
            s2_ur_reg     <= s1_ur_reg;
            s2_yy_reg     <= s1_yy_reg;
            s2_uu_hi_reg  <= $signed(s1_uu_reg[PROD_W-1:DATA_W]) * unit_square;
            s2_uu_lo_reg  <= $signed({1'b0, s1_uu_reg[DATA_W-1:0]}) * unit_square;
            s2_vv_hi_reg  <= $signed(s1_vv_reg[PROD_W-1:DATA_W]) * unit_square;
            s2_vv_lo_reg  <= $signed({1'b0, s1_vv_reg[DATA_W-1:0]}) * unit_square;

            s3_op_reg     <= s2_op_reg;
            s3_lin_re_reg <= s2_lin_re_reg;
            s3_lin_un_reg <= s2_lin_un_reg;
            s3_rr_reg     <= s2_rr_reg;
            s3_ru_reg     <= s2_ru_reg;
            s3_ur_reg     <= s2_ur_reg;
            s3_yy_reg     <= s2_yy_reg;
            s3_tuu_reg    <= (TERM_W'(s2_uu_hi_reg) <<< DATA_W) + TERM_W'(s2_uu_lo_reg);
            s3_tvv_reg    <= (TERM_W'(s2_vv_hi_reg) <<< DATA_W) + TERM_W'(s2_vv_lo_reg);

            s4_op_reg     <= s3_op_reg;
            s4_re_reg     <= sum_re;
            s4_un_reg     <= sum_un;
            s4_den_reg    <= sum_den;

            s5_op_reg       <= s4_op_reg;
            s5_re_neg_reg   <= s4_re_reg[SUM_W-1];
            s5_un_neg_reg   <= s4_un_reg[CROSS_W-1];
            s5_den_neg_reg  <= s4_den_reg[SUM_W-1];
            s5_re_mag_reg   <= s4_re_reg[SUM_W-1] ? -s4_re_reg : s4_re_reg;
            s5_un_mag_reg   <= s4_un_reg[CROSS_W-1] ? -s4_un_reg : s4_un_reg;
            s5_den_mag_reg  <= s4_den_reg[SUM_W-1] ? -s4_den_reg : s4_den_reg;
            s5_den_zero_reg <= s4_den_reg == '0;
        end
    end

    // Stage valid bits and divider tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            s5_v_reg     <= 1'b0;
            div_busy_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_v_reg <= q_valid;
                s2_v_reg <= s1_v_reg;
                s3_v_reg <= s2_v_reg;
                s4_v_reg <= s3_v_reg;
                s5_v_reg <= s4_v_reg;
            end
            if (div_go) begin
                div_busy_reg <= 1'b1;
            end else if (done_re) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    // Rounding shift and saturation for everything but division.
    always_comb
    begin
        if (s5_op_reg == OP_MUL) begin
            re_sh   = s5_re_mag_reg >> (2 * FRAC_BITS);
            re_half = s5_re_mag_reg[2*FRAC_BITS-1];
            un_sh   = s5_un_mag_reg >> FRAC_BITS;
            un_half = s5_un_mag_reg[FRAC_BITS-1];
        end else begin
            re_sh   = s5_re_mag_reg;
            re_half = 1'b0;
            un_sh   = s5_un_mag_reg;
            un_half = 1'b0;
        end
        re_mag34 = {1'b0, re_sh[DATA_W:0]} + MAG_W'(re_half);
        un_mag34 = {1'b0, un_sh[DATA_W:0]} + MAG_W'(un_half);
        re_res   = sat_mag(s5_re_neg_reg, |re_sh[SUM_W-1:DATA_W+1], re_mag34);
        un_res   = sat_mag(s5_un_neg_reg, |un_sh[CROSS_W-1:DATA_W+1], un_mag34);
    end

    // Result word for the last stage.
    always_comb
    begin
        iss_re = '0;
        iss_un = '0;
        iss_st = ST_OK;
        case (s5_op_reg)
            OP_ADD, OP_SUB, OP_CONJ, OP_MUL: begin
                iss_re = re_res.val;
                iss_un = un_res.val;
                iss_st = (re_res.sat || un_res.sat) ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (div_item) begin
                    iss_re = div_re_res.val;
                    iss_un = div_un_res.val;
                    iss_st = (div_re_res.sat || div_un_res.sat) ? ST_SAT : ST_OK;
                end else begin
                    iss_st = ST_ZERO_DIV;
                end
            end
            default: ;
        endcase
    end

    // Two dividers share the norm and run in lockstep.
    hca_div u_div_re (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .num_mag (NUM_W'(s5_re_mag_reg) << FRAC_BITS),
        .den_mag (s5_den_mag_reg),
        .neg     (s5_re_neg_reg ^ s5_den_neg_reg),
        .done    (done_re),
        .result  (div_re_res)
    );

    hca_div u_div_un (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .num_mag (NUM_W'(s5_un_mag_reg) << (2 * FRAC_BITS)),
        .den_mag (s5_den_mag_reg),
        .neg     (s5_un_neg_reg ^ s5_den_neg_reg),
        .done    (done_un),
        .result  (div_un_res)
    );

    // Output register: one strobe per word leaving the last stage.
    always_ff @(posedge clk)
    begin
        out_re_reg <= iss_re;
        out_un_reg <= iss_un;
        out_st_reg <= iss_st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= s5_v_reg && adv;
        end
    end

    assign done     = out_v_reg;
    assign res_real = out_re_reg;
    assign res_unit = out_un_reg;
    assign status   = out_st_reg;

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_re == done_un)
        else $error("dividers out of step");

    a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ZERO_DIV) |-> (res_real == '0 && res_unit == '0))
        else $error("zero-divisor word carries a nonzero result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_hypercomplex_alu_core.sv =====
// Self-checking testbench for hypercomplex_alu_core: directed table, then random words.
// Depends on hca_pkg and the RTL below rtl/; results are checked against typed answers or a local predictor.
`timescale 1ns / 1ps

module tb_hypercomplex_alu_core;
    import hca_pkg::*;

    localparam int          CLK_HALF    = 2;
    localparam int          RESET_CYC   = 9;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          RAND_WORDS  = 1950;
    localparam logic [2:0]  MODE_SPARE5 = 3'd5;
    localparam logic [2:0]  MODE_SPARE6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE7 = 3'd7;
    localparam logic [31:0] S32_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;
    localparam logic [31:0] ONE_Q       = 32'h0001_0000;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] un;
        logic [1:0]  st;
    } word_res_t;

    typedef struct {
        logic [2:0]  md;
        logic [31:0] xr, xu, yr, yu;
        bit          typed;
        word_res_t   res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        start = 1'b0;
    logic [2:0]  mode = '0;
    logic [31:0] x_real = '0, x_unit = '0, y_real = '0, y_unit = '0;
    logic        busy, done;
    logic [31:0] res_real, res_unit;
    logic [1:0]  status;

    // Expected word for the row being offered, when the table gives it directly.
    bit          row_typed = 1'b0;
    word_res_t   row_res;

    logic signed [31:0] unit_sq_shadow = UNIT_SQ_RESET;
    word_res_t          pending_q[$];
    int                 fail_cnt = 0;
    int                 cycle_cnt = 0;
    int                 idle_pct = 0;

    hypercomplex_alu_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .start(start), .mode(mode),
        .x_real(x_real), .x_unit(x_unit), .y_real(y_real), .y_unit(y_unit),
        .busy(busy), .done(done),
        .res_real(res_real), .res_unit(res_unit), .status(status)
    );

    always #(CLK_HALF) clk = ~clk;

    // Round a / 2^k to nearest, ties away from zero.
    function automatic wide_t round_shift(input wide_t a, input int k);
        wide_t q;
        wide_t m;
        m = (a < 0) ? -a : a;
        q = (m >> k) + ((m >> (k - 1)) & 1);
        return (a < 0) ? -q : q;
    endfunction

    // Rounded quotient n / d with ties away from zero.
    function automatic wide_t round_quot(input wide_t n, input wide_t d);
        logic [255:0] nm;
        logic [255:0] dm;
        logic [255:0] q;
        logic [255:0] r;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q  = nm / dm;
        r  = nm % dm;
        if ((r << 1) >= dm)
            q = q + 1;
        return ((n < 0) != (d < 0)) ? -wide_t'(q) : wide_t'(q);
    endfunction

    // Clamp to the signed 32-bit range and note any clamping.
    function automatic logic [31:0] clamp32(input wide_t a, inout bit sat);
        if (a > wide_t'(32'sh7fff_ffff)) begin
            sat = 1'b1;
            return S32_MAX;
        end
        if (a < -(wide_t'(1) <<< 31)) begin
            sat = 1'b1;
            return S32_MIN;
        end
        return a[31:0];
    endfunction

    // Expected word for one operation under the current value of u*u.
    function automatic word_res_t hc_predict(input logic [2:0] md,
                                             input logic signed [31:0] ixr, ixu,
                                             input logic signed [31:0] iyr, iyu,
                                             input logic signed [31:0] iu2);
        word_res_t o;
        wide_t     xr, xu, yr, yu, u2, re, un, den, nr, nu;
        bit        sat;
        xr = ixr; xu = ixu; yr = iyr; yu = iyu; u2 = iu2;
        re = 0; un = 0; sat = 1'b0;
        o.st = ST_OK;
        case (md)
            MODE_ADD: begin
                re = xr + yr;
                un = xu + yu;
            end
            MODE_SUB: begin
                re = xr - yr;
                un = xu - yu;
            end
            MODE_MUL: begin
                re = round_shift(((xr * yr) <<< FRAC_BITS) + xu * yu * u2, 2 * FRAC_BITS);
                un = round_shift(xr * yu + xu * yr, FRAC_BITS);
            end
            MODE_CONJ: begin
                re = xr;
                un = -xu;
            end
            MODE_DIV: begin
                den = ((yr * yr) <<< FRAC_BITS) - yu * yu * u2;
                if (den == 0) begin
                    o.st = ST_ZERO_DIV;
                end else begin
                    nr = ((xr * yr) <<< FRAC_BITS) - xu * yu * u2;
                    nu = yr * xu - xr * yu;
                    re = round_quot(nr <<< FRAC_BITS, den);
                    un = round_quot(nu <<< (2 * FRAC_BITS), den);
                end
            end
            default: ;
        endcase
        o.re = clamp32(re, sat);
        o.un = clamp32(un, sat);
        if (o.st == ST_OK && sat)
            o.st = ST_SAT;
        return o;
    endfunction

    // Capture accepted words and register writes; check every result strobe.
    always @(posedge clk) begin
        word_res_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && cfg_wr_en)
            unit_sq_shadow <= cfg_wr_data;
        if (rst_n && start && !busy) begin
            if (row_typed)
                pending_q.push_back(row_res);
            else
                pending_q.push_back(hc_predict(mode, x_real, x_unit, y_real, y_unit,
                                               unit_sq_shadow));
        end
        if (rst_n && done) begin
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected: %h %h %0d",
                       res_real, res_unit, status);
                fail_cnt = fail_cnt + 1;
            end else begin
                want = pending_q.pop_front();
                if (res_real !== want.re) begin
                    $error("res_real expected %h actual %h", want.re, res_real);
                    fail_cnt = fail_cnt + 1;
                end
                if (res_unit !== want.un) begin
                    $error("res_unit expected %h actual %h", want.un, res_unit);
                    fail_cnt = fail_cnt + 1;
                end
                if (status !== want.st) begin
                    $error("status expected %0d actual %0d", want.st, status);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    // Offer one word, idling first at the current rate, and hold it until taken.
    task automatic send_word(input stim_row_t w);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        mode      <= w.md;
        x_real    <= w.xr;
        x_unit    <= w.xu;
        y_real    <= w.yr;
        y_unit    <= w.yu;
        row_typed <= w.typed;
        row_res   <= w.res;
        do @(posedge clk); while (busy);
    endtask

    // Let the block drain, then load a new value of u*u.
    task automatic write_unit_sq(input logic [31:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Random operand: mostly moderate values so products stay in range.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
        endcase
    endfunction

    function automatic stim_row_t rand_row(input logic signed [31:0] u2);
        stim_row_t w;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 3)
            w.md = 3'($urandom_range(MODE_SPARE5, MODE_SPARE7));
        else
            w.md = 3'($urandom_range(MODE_ADD, MODE_DIV));
        w.xr = rand_operand();
        w.xu = rand_operand();
        w.yr = rand_operand();
        w.yu = rand_operand();
        // Force a zero norm now and then for the current u*u.
        if (w.md == MODE_DIV && $urandom_range(9) == 0) begin
            if (u2 == 0)
                w.yr = 0;
            else if (u2 == ONE_Q)
                w.yr = ($urandom_range(1)) ? w.yu : -w.yu;
            else begin
                w.yr = 0;
                w.yu = 0;
            end
        end
        w.typed = 1'b0;
        w.res   = '{default: '0};
        return w;
    endfunction

    stim_row_t   dir_rows[$];
    logic [31:0] cfg_vals[6];

    initial begin
        // Directed words at reset u*u; some known answers are typed in.
        dir_rows = '{
            '{MODE_ADD, 0, 0, 0, 0, 1, '{0, 0, ST_OK}},
            '{MODE_ADD, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 1, '{S32_MAX, S32_MAX, ST_SAT}},
            '{MODE_SUB, S32_MIN, 0, 1, 0, 1, '{S32_MIN, 0, ST_SAT}},
            '{MODE_SUB, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1, '{0, 0, ST_OK}},
            '{MODE_CONJ, 5, S32_MIN, 7, 9, 1, '{5, S32_MAX, ST_SAT}},
            '{MODE_CONJ, S32_MAX, S32_MAX, 0, 0, 1, '{S32_MAX, S32_MIN + 1, ST_OK}},
            '{MODE_DIV, ONE_Q, ONE_Q, 0, 0, 1, '{0, 0, ST_ZERO_DIV}},
            '{MODE_SPARE5, S32_MAX, 1, 2, 3, 1, '{0, 0, ST_OK}},
            '{MODE_SPARE6, S32_MIN, 1, 2, 3, 1, '{0, 0, ST_OK}},
            '{MODE_SPARE7, 1, S32_MIN, S32_MAX, 3, 1, '{0, 0, ST_OK}},
            '{MODE_MUL, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, '{0, 0, ST_OK}},
            '{MODE_MUL, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 0, '{0, 0, ST_OK}},
            '{MODE_MUL, S32_MIN, S32_MIN, S32_MIN, S32_MAX, 0, '{0, 0, ST_OK}},
            '{MODE_MUL, 3, 32'hffff_fffd, 32'h8000, 32'h8000, 0, '{0, 0, ST_OK}},
            '{MODE_DIV, ONE_Q, 0, ONE_Q, 0, 0, '{0, 0, ST_OK}},
            '{MODE_DIV, S32_MAX, S32_MIN, 1, 1, 0, '{0, 0, ST_OK}},
            '{MODE_DIV, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 0, '{0, 0, ST_OK}},
            '{MODE_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 32'hffff_8000,
              0, '{0, 0, ST_OK}},
            '{MODE_DIV, 1, 1, 3, 0, 0, '{0, 0, ST_OK}}
        };
        cfg_vals = '{32'h0000_0000, ONE_Q, S32_MAX, S32_MIN, $urandom(), UNIT_SQ_RESET};

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i]);

        // Random words under each u*u setting, idling 7%, then 54%, then never.
        foreach (cfg_vals[p]) begin
            write_unit_sq(cfg_vals[p]);
            for (int n = 0; n < RAND_WORDS / 6; n++) begin
                idle_pct = (p < 2) ? 7 : (p < 4) ? 54 : 0;
                send_word(rand_row(cfg_vals[p]));
            end
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
